/* rtl/core/pi_aw_lpf_pkg.sv */
// ----------------------------------------------------------------------------
// PI controller package
// Shared constants, control word types and the microcode program of the
// incremental PI controller with anti-windup and measurement filter.
// ----------------------------------------------------------------------------
package pi_aw_lpf_pkg;

	// Default data format: signed Q16.16.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Sample period is Q0.16, filter coefficient is Q1.15.
	localparam int DT_FRAC    = 16;
	localparam int COEF_FRAC  = 15;
	localparam logic [15:0] COEF_ONE = 16'h8000;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED       = 3'd7;

	// Step counter of the sequencer.
	typedef logic [3:0] step_t;

	localparam step_t STEP_WAIT    = 4'd0;
	localparam step_t STEP_DIFF    = 4'd1;
	localparam step_t STEP_FMUL_A  = 4'd2;
	localparam step_t STEP_FMUL_B  = 4'd3;
	localparam step_t STEP_FSUM    = 4'd4;
	localparam step_t STEP_IMUL_G  = 4'd5;
	localparam step_t STEP_ISCL_G  = 4'd6;
	localparam step_t STEP_IMUL_DT = 4'd7;
	localparam step_t STEP_ISCL_DT = 4'd8;
	localparam step_t STEP_PMUL    = 4'd9;
	localparam step_t STEP_PSCL    = 4'd10;
	localparam step_t STEP_SUB_P   = 4'd11;
	localparam step_t STEP_COMMIT  = 4'd12;
	localparam step_t STEP_ZERO    = 4'd13;

	// Datapath operation of one step.
	typedef enum logic [3:0] {
		ALU_NONE,
		ALU_LOAD,
		ALU_DIFF,
		ALU_FSUM,
		ALU_SCALE_G,
		ALU_SCALE_DT,
		ALU_ADD_LAST,
		ALU_SUB_P,
		ALU_COMMIT,
		ALU_ZERO
	} alu_t;

	// Multiplier operand selects.
	typedef enum logic [1:0] {
		A_FC,
		A_X,
		A_ERR,
		A_TERM
	} asel_t;

	typedef enum logic [2:0] {
		B_COEF,
		B_COEF_INV,
		B_GAIN_I,
		B_DT,
		B_GAIN_P
	} bsel_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ACCEPT,
		COND_DISABLED,
		COND_SKIP_FILT,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		alu_t  alu;
		logic  mul_en;
		logic  save_prod;
		asel_t a_sel;
		bsel_t b_sel;
		cond_t cond;
		step_t target;
		logic  last;
	} ucode_t;

	function automatic ucode_t uc(input alu_t alu, input logic mul_en, input logic save_prod,
			input asel_t a_sel, input bsel_t b_sel, input cond_t cond, input step_t target,
			input logic last);
		ucode_t w;
		w.alu       = alu;
		w.mul_en    = mul_en;
		w.save_prod = save_prod;
		w.a_sel     = a_sel;
		w.b_sel     = b_sel;
		w.cond      = cond;
		w.target    = target;
		w.last      = last;
		return w;
	endfunction

	// The program. A taken jump goes to target; otherwise the last step of a
	// sample returns to the wait step and every other step falls through.
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		case (pc)
			STEP_WAIT:    w = uc(ALU_LOAD,     1'b0, 1'b0, A_X,    B_DT,
				COND_NO_ACCEPT, STEP_WAIT, 1'b0);
			STEP_DIFF:    w = uc(ALU_DIFF,     1'b0, 1'b0, A_X,    B_DT,
				COND_DISABLED, STEP_ZERO, 1'b0);
			STEP_FMUL_A:  w = uc(ALU_NONE,     1'b1, 1'b0, A_FC,   B_COEF,
				COND_SKIP_FILT, STEP_IMUL_G, 1'b0);
			STEP_FMUL_B:  w = uc(ALU_NONE,     1'b1, 1'b1, A_X,    B_COEF_INV,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_FSUM:    w = uc(ALU_FSUM,     1'b0, 1'b0, A_X,    B_DT,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_IMUL_G:  w = uc(ALU_NONE,     1'b1, 1'b0, A_ERR,  B_GAIN_I,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_ISCL_G:  w = uc(ALU_SCALE_G,  1'b0, 1'b0, A_X,    B_DT,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_IMUL_DT: w = uc(ALU_NONE,     1'b1, 1'b0, A_TERM, B_DT,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_ISCL_DT: w = uc(ALU_SCALE_DT, 1'b0, 1'b0, A_X,    B_DT,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_PMUL:    w = uc(ALU_ADD_LAST, 1'b1, 1'b0, A_X,    B_GAIN_P,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_PSCL:    w = uc(ALU_SCALE_G,  1'b0, 1'b0, A_X,    B_DT,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_SUB_P:   w = uc(ALU_SUB_P,    1'b0, 1'b0, A_X,    B_DT,
				COND_NEVER, STEP_WAIT, 1'b0);
			STEP_COMMIT:  w = uc(ALU_COMMIT,   1'b0, 1'b0, A_X,    B_DT,
				COND_OUT_BUSY, STEP_COMMIT, 1'b1);
			STEP_ZERO:    w = uc(ALU_ZERO,     1'b0, 1'b0, A_X,    B_DT,
				COND_OUT_BUSY, STEP_ZERO, 1'b1);
			default:      w = uc(ALU_NONE,     1'b0, 1'b0, A_X,    B_DT,
				COND_ALWAYS, STEP_WAIT, 1'b0);
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/pi_controller_antiwindup_lpf_unit.sv */
// ----------------------------------------------------------------------------
// Incremental PI controller with anti-windup and measurement filter
// Returns a clamped drive per sample from a measured value and a target, or zero while disabled.
// ----------------------------------------------------------------------------
// Each sample runs the program: difference, filter (skipped when off or on
// the first sample), I and P terms, then commit; a disabled sample outputs
// zero instead. One multiplier is shared by all steps. No new item is taken
// until the result is loaded, which waits while an older drive is not taken.
// Reset clears the state, loads the register defaults and arms the
// first-sample flag; the block is ready for an item right after reset.
module pi_controller_antiwindup_lpf_unit #(
	parameter int DATA_WIDTH = pi_aw_lpf_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pi_aw_lpf_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    cfg_we,
	input  logic [pi_aw_lpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pi_aw_lpf_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [DATA_WIDTH-1:0]            measured,
	input  logic signed [DATA_WIDTH-1:0]            target,

	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [DATA_WIDTH-1:0]            drive
);
	import pi_aw_lpf_pkg::*;

	// Product width: a data word times an unsigned 32-bit factor. All wide
	// intermediates (filter sum, clamp compare) live at this width too.
	localparam int PW = DATA_WIDTH + 33;

	localparam logic signed [PW-1:0] TOP_W = {{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [PW-1:0] BOT_W = ~TOP_W;

	// Saturate a wide signed value to the data range.
	function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [PW-1:0] x);
		logic signed [DATA_WIDTH-1:0] r;
		if (x > TOP_W) begin
			r = TOP_W[DATA_WIDTH-1:0];
		end else if (x < BOT_W) begin
			r = BOT_W[DATA_WIDTH-1:0];
		end else begin
			r = x[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

	// Arithmetic right shift that rounds toward zero. Called with constant
	// shift amounts only, so it reduces to wiring and an incrementer.
	function automatic logic signed [PW-1:0] tz_shift(input logic signed [PW-1:0] x,
			input int s);
		logic [PW-1:0]        mask;
		logic signed [PW-1:0] q;
		mask = ~({PW{1'b1}} << s);
		q    = x >>> s;
		if (x[PW-1] && ((x & mask) != '0)) begin
			q = q + {{(PW-1){1'b0}}, 1'b1};
		end
		return q;
	endfunction

	function automatic logic signed [PW-1:0] ext_d(input logic signed [DATA_WIDTH-1:0] v);
		return PW'(v);
	endfunction

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [30:0]        gain_p_q;
	logic [30:0]        gain_i_q;
	logic [15:0]        period_q;
	logic [15:0]        coef_q;
	logic signed [31:0] drive_min_q;
	logic signed [31:0] drive_max_q;
	logic               filt_en_q;
	logic               enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			period_q    <= 16'd655;
			coef_q      <= '0;
			drive_min_q <= 32'sh8000_0000;
			drive_max_q <= 32'sh7FFF_FFFF;
			filt_en_q   <= 1'b0;
			enabled_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN_P:        gain_p_q    <= cfg_data[30:0];
				CFG_GAIN_I:        gain_i_q    <= cfg_data[30:0];
				CFG_SAMPLE_PERIOD: period_q    <= cfg_data[15:0];
				CFG_FILTER_COEF:   coef_q      <= cfg_data[15:0];
				CFG_DRIVE_MIN:     drive_min_q <= $signed(cfg_data[31:0]);
				CFG_DRIVE_MAX:     drive_max_q <= $signed(cfg_data[31:0]);
				CFG_FILTER_ENABLE: filt_en_q   <= cfg_data[0];
				CFG_ENABLED:       enabled_q   <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// Coefficients above one act as one.
	logic [15:0] coef_clip;
	logic [15:0] coef_inv;

	assign coef_clip = (coef_q > COEF_ONE) ? COEF_ONE : coef_q;
	assign coef_inv  = COEF_ONE - coef_clip;

	// Controller state.
	logic signed [DATA_WIDTH-1:0] last_m_q;
	logic signed [DATA_WIDTH-1:0] fc_q;
	logic signed [DATA_WIDTH-1:0] last_drive_q;
	logic                         first_q;

	// ------------------------------------------------------------------------
	// Sequencer: the step counter addresses the program and the fetched
	// control word steers the datapath for that cycle.
	// ------------------------------------------------------------------------
	step_t  pc_q;
	step_t  pc_d;
	ucode_t uw;
	logic   accept;
	logic   out_busy;
	logic   take;
	logic   commit_fire;
	logic   zero_fire;
	logic   out_valid_q;

	assign uw       = ucode_rom(pc_q);
	assign in_ready = (pc_q == STEP_WAIT);
	assign accept   = in_valid && in_ready;
	// The output register holds an item that is not taken this cycle.
	assign out_busy = out_valid_q && !out_ready;

	always_comb begin
		case (uw.cond)
			COND_NEVER:     take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_NO_ACCEPT: take = !accept;
			COND_DISABLED:  take = !enabled_q;
			COND_SKIP_FILT: take = !filt_en_q || first_q;
			COND_OUT_BUSY:  take = out_busy;
			default:        take = 1'b0;
		endcase
	end

	always_comb begin
		if (take) begin
			pc_d = uw.target;
		end else if (uw.last) begin
			pc_d = STEP_WAIT;
		end else begin
			pc_d = pc_q + 4'd1;
		end
	end

	// Results leave only when the output register is free or being emptied.
	assign commit_fire = (uw.alu == ALU_COMMIT) && !out_busy;
	assign zero_fire   = (uw.alu == ALU_ZERO) && !out_busy;

	// ------------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------------
	logic signed [DATA_WIDTH-1:0] m_q;
	logic signed [DATA_WIDTH-1:0] tg_q;
	logic signed [DATA_WIDTH-1:0] err_q;
	logic signed [DATA_WIDTH-1:0] x_q;      // measurement change, then filtered change
	logic signed [DATA_WIDTH-1:0] term_q;   // scaled product of the last multiply
	logic signed [DATA_WIDTH-1:0] d_q;      // drive before the clamp
	logic signed [PW-1:0]         prod_q;
	logic signed [PW-1:0]         acc_q;
	logic signed [DATA_WIDTH-1:0] drive_q;

	// Shared multiplier: signed data word times unsigned 32-bit factor.
	logic signed [DATA_WIDTH-1:0] mul_a;
	logic [31:0]                  mul_b;
	logic signed [PW-1:0]         mul_p;

	always_comb begin
		case (uw.a_sel)
			A_FC:    mul_a = fc_q;
			A_X:     mul_a = x_q;
			A_ERR:   mul_a = err_q;
			A_TERM:  mul_a = term_q;
			default: mul_a = x_q;
		endcase
	end

	always_comb begin
		case (uw.b_sel)
			B_COEF:     mul_b = {16'd0, coef_clip};
			B_COEF_INV: mul_b = {16'd0, coef_inv};
			B_GAIN_I:   mul_b = {1'b0, gain_i_q};
			B_DT:       mul_b = {16'd0, period_q};
			B_GAIN_P:   mul_b = {1'b0, gain_p_q};
			default:    mul_b = '0;
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, mul_b});

	// Clamp to the drive limits (minimum wins when they cross), then
	// saturate to the data range.
	logic signed [PW-1:0]         clamp_w;
	logic signed [DATA_WIDTH-1:0] clamped;

	always_comb begin
		clamp_w = ext_d(d_q);
		if (clamp_w > PW'(drive_max_q)) begin
			clamp_w = PW'(drive_max_q);
		end
		if (clamp_w < PW'(drive_min_q)) begin
			clamp_w = PW'(drive_min_q);
		end
		clamped = sat_w(clamp_w);
	end

	// Working registers carry no reset.
	always_ff @(posedge clk) begin
		if (uw.mul_en) begin
			prod_q <= mul_p;
		end
		if (uw.save_prod) begin
			acc_q <= prod_q;
		end
		case (uw.alu)
			ALU_LOAD: begin
				if (accept) begin
					m_q  <= measured;
					tg_q <= target;
				end
			end
			ALU_DIFF: begin
				err_q <= sat_w(ext_d(tg_q) - ext_d(m_q));
				// The first sample sees no change of the measurement.
				x_q   <= first_q ? '0 : sat_w(ext_d(m_q) - ext_d(last_m_q));
			end
			ALU_FSUM: begin
				x_q <= sat_w(tz_shift(acc_q + prod_q, COEF_FRAC));
			end
			ALU_SCALE_G: begin
				term_q <= sat_w(tz_shift(prod_q, FRAC_BITS));
			end
			ALU_SCALE_DT: begin
				term_q <= sat_w(tz_shift(prod_q, DT_FRAC));
			end
			ALU_ADD_LAST: begin
				d_q <= sat_w(ext_d(last_drive_q) + ext_d(term_q));
			end
			ALU_SUB_P: begin
				d_q <= sat_w(ext_d(d_q) - ext_d(term_q));
			end
			ALU_COMMIT: begin
				if (commit_fire) begin
					drive_q <= clamped;
				end
			end
			ALU_ZERO: begin
				if (zero_fire) begin
					drive_q <= '0;
				end
			end
			default: ;
		endcase
	end

	// Control and controller state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= STEP_WAIT;
			out_valid_q  <= 1'b0;
			last_m_q     <= '0;
			fc_q         <= '0;
			last_drive_q <= '0;
			first_q      <= 1'b1;
		end else begin
			pc_q <= pc_d;
			if (commit_fire || zero_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// A disabled sample leaves the state untouched.
			if (commit_fire) begin
				last_m_q     <= m_q;
				fc_q         <= x_q;
				last_drive_q <= clamped;
				first_q      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	// The first-sample flag is only cleared by a committed sample.
	a_first_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> $past(pc_q) == STEP_COMMIT)
		else $error("first-sample flag cleared outside commit");

	// A disabled sample must not disturb the controller state.
	a_zero_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_ZERO) |=> $stable(last_drive_q) && $stable(fc_q) && $stable(last_m_q))
		else $error("controller state changed on a disabled sample");

	// An accepted item always starts the program at the difference step.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pc_q == STEP_DIFF)
		else $error("sequencer did not start after accept");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(drive_q) && out_valid_q)
		else $error("pending drive overwritten");

endmodule
